>>> hdl/nhd_pkg.sv
// Shared types, constants and size helpers for the cartridge header decoder.
`timescale 1ns / 1ps

package nhd_pkg;

  // One input transaction: a header byte and its resynchronization mark.
  typedef struct packed {
    logic [7:0] header_byte;
    logic       restart;
  } in_item_t;

  // One result transaction: a tagged field of the decoded header.
  typedef struct packed {
    logic [4:0]  field_tag;
    logic [63:0] field_value;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  // Field tags, in emission order.
  localparam logic [4:0] TAG_MIRROR      = 5'd0;
  localparam logic [4:0] TAG_BATTERY     = 5'd1;
  localparam logic [4:0] TAG_TRAINER     = 5'd2;
  localparam logic [4:0] TAG_FOUR_SCREEN = 5'd3;
  localparam logic [4:0] TAG_CONSOLE     = 5'd4;
  localparam logic [4:0] TAG_NES20       = 5'd5;
  localparam logic [4:0] TAG_MAPPER      = 5'd6;
  localparam logic [4:0] TAG_SUBMAPPER   = 5'd7;
  localparam logic [4:0] TAG_PRG_ROM     = 5'd8;
  localparam logic [4:0] TAG_CHR_ROM     = 5'd9;
  localparam logic [4:0] TAG_PRG_RAM     = 5'd10;
  localparam logic [4:0] TAG_EEPROM      = 5'd11;
  localparam logic [4:0] TAG_CHR_RAM     = 5'd12;
  localparam logic [4:0] TAG_CHR_NVRAM   = 5'd13;
  localparam logic [4:0] TAG_TIMING      = 5'd14;
  localparam logic [4:0] TAG_VS_PPU      = 5'd15;
  localparam logic [4:0] TAG_VS_HW       = 5'd16;
  localparam logic [4:0] TAG_EXT_CONSOLE = 5'd17;
  localparam logic [4:0] TAG_MISC_COUNT  = 5'd18;
  localparam logic [4:0] TAG_EXPANSION   = 5'd19;
  localparam logic [4:0] TAG_PRG_OFF     = 5'd20;
  localparam logic [4:0] TAG_CHR_OFF     = 5'd21;
  localparam logic [4:0] TAG_MISC_OFF    = 5'd22;
  localparam logic [4:0] TAG_MISC_SIZE   = 5'd23;

  // Header signature "NES" followed by the end-of-file marker.
  localparam logic [7:0] SIG_0 = 8'h4e;
  localparam logic [7:0] SIG_1 = 8'h45;
  localparam logic [7:0] SIG_2 = 8'h53;
  localparam logic [7:0] SIG_3 = 8'h1a;

  localparam logic [3:0]  LAST_SLOT     = 4'd15;
  localparam logic [3:0]  EXP_FORM      = 4'hf;
  localparam logic [4:0]  PRG_UNIT_LOG2 = 5'd14;  // 16 KiB blocks
  localparam logic [4:0]  CHR_UNIT_LOG2 = 5'd13;  // 8 KiB blocks
  localparam logic [63:0] HEADER_LEN    = 64'd16;
  localparam logic [63:0] TRAINER_LEN   = 64'd512;
  localparam logic [63:0] RAM_BASE      = 64'd64;
  localparam logic [1:0]  NES20_MARK    = 2'b10;
  localparam logic [1:0]  CONSOLE_VS    = 2'd1;
  localparam logic [1:0]  CONSOLE_EXT   = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic       store_en;
    logic       calc_size;
    logic       calc_chr_off;
    logic       calc_misc_off;
    logic       calc_misc;
    logic       out_load;
    logic       out_bad;
    logic [4:0] tag;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic header_done;
    logic sig_ok;
  } stat_t;

  typedef struct packed {
    logic [63:0] value;
    logic        sat;
  } size_t;

  // ROM size, either block count times unit or the 2^E * (2M+1) form.
  function automatic size_t rom_size(input logic [7:0] lsb, input logic [3:0] nib,
                                     input logic [4:0] unit_log2);
    size_t       res;
    logic [66:0] wide;
    logic [63:0] blocks;
    blocks = {52'd0, nib, lsb};
    wide   = {64'd0, lsb[1:0], 1'b1} << lsb[7:2];
    if (nib != EXP_FORM) begin
      res.value = blocks << unit_log2;
      res.sat   = 1'b0;
    end else begin
      res.sat   = |wide[66:64];
      res.value = res.sat ? '1 : wide[63:0];
    end
    return res;
  endfunction

  // RAM size from a shift count; zero means no RAM.
  function automatic logic [63:0] ram_size(input logic [3:0] shift);
    return (shift != 4'd0) ? (RAM_BASE << shift) : 64'd0;
  endfunction

endpackage

>>> hdl/nhd_ctrl.sv
// Controller state machine: byte collection, offset steps and result sequencing.
`timescale 1ns / 1ps

module nhd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  nhd_pkg::stat_t stat,
  output nhd_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_CHR_OFF,
    S_MISC_OFF,
    S_MISC,
    S_EMIT,
    S_BAD
  } state_t;

  state_t     state;
  logic [4:0] tag;
  logic       accept;
  logic       load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  // The output register takes a new result when empty or when being drained.
  assign load     = ((state == S_EMIT) || (state == S_BAD)) && (!out_valid || !out_stall);

  always_comb begin
    cmd               = '0;
    cmd.store_en      = accept;
    cmd.calc_size     = (state == S_SIZE);
    cmd.calc_chr_off  = (state == S_CHR_OFF);
    cmd.calc_misc_off = (state == S_MISC_OFF);
    cmd.calc_misc     = (state == S_MISC);
    cmd.out_load      = load;
    cmd.out_bad       = (state == S_BAD);
    cmd.tag           = tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tag       <= nhd_pkg::TAG_MIRROR;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && stat.header_done) begin
            state <= S_SIZE;
          end
        end
        S_SIZE: begin
          state <= stat.sig_ok ? S_CHR_OFF : S_BAD;
        end
        S_CHR_OFF: begin
          state <= S_MISC_OFF;
        end
        S_MISC_OFF: begin
          state <= S_MISC;
        end
        S_MISC: begin
          state <= S_EMIT;
          tag   <= nhd_pkg::TAG_MIRROR;
        end
        S_EMIT: begin
          if (load) begin
            if (tag == nhd_pkg::TAG_MISC_SIZE) begin
              state <= S_IDLE;
            end else begin
              tag <= tag + 5'd1;
            end
          end
        end
        S_BAD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/nhd_dp.sv
// Datapath: header byte store, size and offset registers, field select and result register.
`timescale 1ns / 1ps

module nhd_dp (
  input  logic               clk,
  input  logic               rst,
  input  nhd_pkg::in_item_t  in_data,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  nhd_pkg::cmd_t      cmd,
  output nhd_pkg::stat_t     stat,
  output nhd_pkg::out_item_t out_data
);

  logic [7:0]  store [16];
  logic [3:0]  pos;
  logic [3:0]  slot;
  logic [31:0] image_length;

  nhd_pkg::size_t prg_size;
  nhd_pkg::size_t chr_size;
  logic [63:0] prg;
  logic [63:0] chr;
  logic        prg_sat;
  logic        chr_sat;
  logic [63:0] prg_off;
  logic [63:0] chr_off;
  logic        chr_off_sat;
  logic [63:0] misc_off;
  logic        misc_off_sat;
  logic [63:0] misc;
  logic        misc_short;
  logic [64:0] sum_chr;
  logic [64:0] sum_misc;
  logic [63:0] image_wide;
  logic [1:0]  ctype;
  logic [63:0] value;
  logic [1:0]  status;

  assign slot             = in_data.restart ? 4'd0 : pos;
  assign stat.header_done = (slot == nhd_pkg::LAST_SLOT);
  assign stat.sig_ok      = (store[0] == nhd_pkg::SIG_0) && (store[1] == nhd_pkg::SIG_1) &&
                            (store[2] == nhd_pkg::SIG_2) && (store[3] == nhd_pkg::SIG_3);

  assign ctype      = store[7][1:0];
  assign prg_size   = nhd_pkg::rom_size(store[4], store[9][3:0], nhd_pkg::PRG_UNIT_LOG2);
  assign chr_size   = nhd_pkg::rom_size(store[5], store[9][7:4], nhd_pkg::CHR_UNIT_LOG2);
  assign prg_off    = store[6][2] ? (nhd_pkg::HEADER_LEN + nhd_pkg::TRAINER_LEN)
                                  : nhd_pkg::HEADER_LEN;
  assign sum_chr    = {1'b0, prg_off} + {1'b0, prg};
  assign sum_misc   = {1'b0, chr_off} + {1'b0, chr};
  assign image_wide = {32'd0, image_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= 4'd0;
      image_length <= 32'd0;
    end else begin
      if (cmd.store_en) begin
        pos <= slot + 4'd1;
      end
      if (cfg_write) begin
        image_length <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_en) begin
      store[slot] <= in_data.header_byte;
    end
    if (cmd.calc_size) begin
      prg     <= prg_size.value;
      prg_sat <= prg_size.sat;
      chr     <= chr_size.value;
      chr_sat <= chr_size.sat;
    end
    if (cmd.calc_chr_off) begin
      chr_off_sat <= sum_chr[64];
      chr_off     <= sum_chr[64] ? '1 : sum_chr[63:0];
    end
    if (cmd.calc_misc_off) begin
      misc_off_sat <= sum_misc[64];
      misc_off     <= sum_misc[64] ? '1 : sum_misc[63:0];
    end
    if (cmd.calc_misc) begin
      misc_short <= (image_wide < misc_off);
      misc       <= (image_wide < misc_off) ? 64'd0 : (image_wide - misc_off);
    end
  end

  always_comb begin
    status = nhd_pkg::ST_OK;
    case (cmd.tag)
      nhd_pkg::TAG_MIRROR:      value = {63'd0, store[6][0]};
      nhd_pkg::TAG_BATTERY:     value = {63'd0, store[6][1]};
      nhd_pkg::TAG_TRAINER:     value = {63'd0, store[6][2]};
      nhd_pkg::TAG_FOUR_SCREEN: value = {63'd0, store[6][3]};
      nhd_pkg::TAG_CONSOLE:     value = {62'd0, ctype};
      nhd_pkg::TAG_NES20:       value = {63'd0, store[7][3:2] == nhd_pkg::NES20_MARK};
      nhd_pkg::TAG_MAPPER:      value = {52'd0, store[8][3:0], store[7][7:4], store[6][7:4]};
      nhd_pkg::TAG_SUBMAPPER:   value = {60'd0, store[8][7:4]};
      nhd_pkg::TAG_PRG_ROM: begin
        value  = prg;
        status = prg_sat ? nhd_pkg::ST_SAT : nhd_pkg::ST_OK;
      end
      nhd_pkg::TAG_CHR_ROM: begin
        value  = chr;
        status = chr_sat ? nhd_pkg::ST_SAT : nhd_pkg::ST_OK;
      end
      nhd_pkg::TAG_PRG_RAM:     value = nhd_pkg::ram_size(store[10][3:0]);
      nhd_pkg::TAG_EEPROM:      value = nhd_pkg::ram_size(store[10][7:4]);
      nhd_pkg::TAG_CHR_RAM:     value = nhd_pkg::ram_size(store[11][3:0]);
      nhd_pkg::TAG_CHR_NVRAM:   value = nhd_pkg::ram_size(store[11][7:4]);
      nhd_pkg::TAG_TIMING:      value = {62'd0, store[12][1:0]};
      nhd_pkg::TAG_VS_PPU:
        value = (ctype == nhd_pkg::CONSOLE_VS) ? {60'd0, store[13][3:0]} : 64'd0;
      nhd_pkg::TAG_VS_HW:
        value = (ctype == nhd_pkg::CONSOLE_VS) ? {60'd0, store[13][7:4]} : 64'd0;
      nhd_pkg::TAG_EXT_CONSOLE:
        value = (ctype == nhd_pkg::CONSOLE_EXT) ? {60'd0, store[13][3:0]} : 64'd0;
      nhd_pkg::TAG_MISC_COUNT:  value = {62'd0, store[14][1:0]};
      nhd_pkg::TAG_EXPANSION:   value = {58'd0, store[15][5:0]};
      nhd_pkg::TAG_PRG_OFF:     value = prg_off;
      nhd_pkg::TAG_CHR_OFF: begin
        value  = chr_off;
        status = chr_off_sat ? nhd_pkg::ST_SAT : nhd_pkg::ST_OK;
      end
      nhd_pkg::TAG_MISC_OFF: begin
        value  = misc_off;
        status = misc_off_sat ? nhd_pkg::ST_SAT : nhd_pkg::ST_OK;
      end
      nhd_pkg::TAG_MISC_SIZE: begin
        value  = misc;
        status = misc_short ? nhd_pkg::ST_SHORT : nhd_pkg::ST_OK;
      end
      default: value = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_bad) begin
        out_data.field_tag   <= nhd_pkg::TAG_MIRROR;
        out_data.field_value <= 64'd0;
        out_data.status      <= nhd_pkg::ST_BAD_SIG;
        out_data.last        <= 1'b1;
      end else begin
        out_data.field_tag   <= cmd.tag;
        out_data.field_value <= value;
        out_data.status      <= status;
        out_data.last        <= (cmd.tag == nhd_pkg::TAG_MISC_SIZE);
      end
    end
  end

endmodule

>>> hdl/nes_rom_header_decoder_unit.sv
// Top level of the cartridge header decoder: controller, datapath and checks.
`timescale 1ns / 1ps

// This unit takes the sixteen header bytes of a cartridge image, one byte per input
// transaction in file order, and decodes them once the sixteenth byte has arrived.
// A byte with restart set is taken as header byte 0. Bytes are accepted one per cycle
// while the unit is collecting; the sixteenth byte then starts the size and offset
// arithmetic (ROM sizes, the two saturating 64-bit offset adds, and the compare and
// subtract against image_length), during which in_stall is high. After that the unit
// emits either one bad-signature result or 24 tagged results, one per cycle when
// out_stall is low, and in_stall stays high until the final result has been loaded
// into the output register. Because the output register separates the two sides,
// collection of the next header begins while the last result still waits to be
// taken. image_length is written through cfg_write and cfg_data and should be
// changed only while the unit is idle.

module nes_rom_header_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  nhd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output nhd_pkg::out_item_t out_data
);

  // Command and status between the controller and the datapath.
  nhd_pkg::cmd_t  cmd;
  nhd_pkg::stat_t stat;

  nhd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  nhd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // A result is never loaded while a byte transaction is being taken.
  a_no_accept_during_run: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> in_stall)
    else $error("input accepted while a result run is in progress");

  // A bad-signature result stands alone: tag 0 and marked last.
  a_bad_sig_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == nhd_pkg::ST_BAD_SIG) |->
      (out_data.last && out_data.field_tag == nhd_pkg::TAG_MIRROR))
    else $error("bad-signature result not a single final result");

  // In a decoded run, only the misc ROM size result closes the run.
  a_last_on_misc_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last && out_data.status != nhd_pkg::ST_BAD_SIG) |->
      (out_data.field_tag == nhd_pkg::TAG_MISC_SIZE))
    else $error("run closed on a field other than misc ROM size");

endmodule
